// ----- hw/rtl/bdd_pkg.sv -----
package bdd_pkg;

    localparam int DIGITS_DEF   = 309;
    localparam int MAX_BITS_DEF = 1024;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 9;
    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 9;

    localparam logic [DIGIT_W-1:0] RADIX = DIGIT_W'(10);

    localparam logic [FUNC_W-1:0] F_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] F_FEED  = 2'd1;
    localparam logic [FUNC_W-1:0] F_READ  = 2'd2;

    typedef struct packed {
        logic clear;   // start of a digit walk: drop both carries
        logic step;    // one digit processed this cycle
        logic add_en;  // fed bit is one: add the power into the result
    } t_alu_ctl;

endpackage

// ----- hw/rtl/bdd_digit_ram.sv -----
module bdd_digit_ram
    import bdd_pkg::*;
#(
    parameter int DEPTH = DIGITS_DEF,
    parameter int AW    = 9
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [DIGIT_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [DIGIT_W-1:0] o_rdata
);

    logic [DIGIT_W-1:0] r_mem [DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bdd_digit_alu.sv -----
module bdd_digit_alu
    import bdd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_alu_ctl           i_ctl,
    input  logic [DIGIT_W-1:0] i_res,
    input  logic [DIGIT_W-1:0] i_pow,
    output logic [DIGIT_W-1:0] o_res,
    output logic [DIGIT_W-1:0] o_pow
);

    logic r_add_c;
    logic r_dbl_c;
    logic n_add_c;
    logic n_dbl_c;
    logic [DIGIT_W:0] sum;
    logic [DIGIT_W:0] dbl;

    always_comb begin
        sum = {1'b0, i_res} + (i_ctl.add_en ? {1'b0, i_pow} : '0)
              + (DIGIT_W+1)'(r_add_c);
        dbl = {i_pow, r_dbl_c};
        n_add_c = (sum >= {1'b0, RADIX});
        n_dbl_c = (dbl >= {1'b0, RADIX});
        o_res = n_add_c ? DIGIT_W'(sum - {1'b0, RADIX}) : sum[DIGIT_W-1:0];
        o_pow = n_dbl_c ? DIGIT_W'(dbl - {1'b0, RADIX}) : dbl[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_c <= 1'b0;
            r_dbl_c <= 1'b0;
        end else if (i_ctl.clear) begin
            r_add_c <= 1'b0;
            r_dbl_c <= 1'b0;
        end else if (i_ctl.step) begin
            r_add_c <= n_add_c;
            r_dbl_c <= n_dbl_c;
        end
    end

endmodule

// ----- hw/rtl/binary_to_decimal_digits.sv -----
// Feed word: busy while it walks the digits from position 0 up to min(power length, DIGITS-1),
// one decimal digit per cycle through the shared add/double digit unit.
// Read word: result strobed on o_valid in the cycle after accept; busy for that single cycle.
// Clear word, unused codes and feeds past MAX_BITS never raise busy.
// Synchronous active-low reset returns the stores to power 1, result 0, no bits fed.
// Results are shown for exactly one cycle; the receiver cannot stall them.
module binary_to_decimal_digits
    import bdd_pkg::*;
#(
    parameter int DIGITS   = DIGITS_DEF,
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic               i_bit_value,
    input  logic [IDX_W-1:0]   i_digit_index,
    output logic               o_valid,
    output logic [DIGIT_W-1:0] o_digit,
    output logic [COUNT_W-1:0] o_digit_count
);

    localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int LW = $clog2(DIGITS + 1);
    localparam int BW = $clog2(MAX_BITS + 1);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_j;
    logic           r_bit;
    logic [LW-1:0]  r_pl;
    logic [LW-1:0]  r_res_len;
    logic [LW-1:0]  r_res_fill;
    logic           r_pow_valid;
    logic [BW-1:0]  r_bits;
    logic           r_hit;

    logic               accept;
    logic               feed_go;
    logic               read_go;
    logic               clear_go;
    logic               walk;
    logic               walk_last;
    logic [LW-1:0]      j_ext;
    logic [LW-1:0]      last;
    logic [AW-1:0]      raddr;
    logic [DIGIT_W-1:0] pow_q;
    logic [DIGIT_W-1:0] res_q;
    logic [DIGIT_W-1:0] pow_val;
    logic [DIGIT_W-1:0] res_val;
    logic [DIGIT_W-1:0] pow_new;
    logic [DIGIT_W-1:0] res_new;
    t_alu_ctl           alu_ctl;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign feed_go  = accept && (i_func == F_FEED) && (r_bits < BW'(MAX_BITS));
    assign read_go  = accept && (i_func == F_READ);
    assign clear_go = accept && (i_func == F_CLEAR);
    assign walk     = (r_state == S_WALK);

    assign j_ext     = LW'(r_j);
    assign last      = (r_pl < LW'(DIGITS)) ? r_pl : LW'(DIGITS - 1);
    assign walk_last = (j_ext == last);

    // Both stores share one read address: next digit while walking, else the read word's index, or zero
    assign raddr = walk ? AW'(j_ext + LW'(1)) :
                   ((i_func == F_READ) ? AW'(i_digit_index) : '0);

    // Entries past the live extent read as zero; before the first doubling the power is one
    always_comb begin
        if (!r_pow_valid) begin
            pow_val = (r_j == '0) ? DIGIT_W'(1) : '0;
        end else begin
            pow_val = (j_ext < r_pl) ? pow_q : '0;
        end
        res_val = (j_ext < r_res_fill) ? res_q : '0;
    end

    assign alu_ctl.clear  = feed_go;
    assign alu_ctl.step   = walk;
    assign alu_ctl.add_en = r_bit;

    bdd_digit_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_res   (res_val),
        .i_pow   (pow_val),
        .o_res   (res_new),
        .o_pow   (pow_new)
    );

    bdd_digit_ram #(.DEPTH(DIGITS), .AW(AW)) u_pow_ram (
        .i_clk   (i_clk),
        .i_we    (walk),
        .i_waddr (r_j),
        .i_wdata (pow_new),
        .i_raddr (raddr),
        .o_rdata (pow_q)
    );

    bdd_digit_ram #(.DEPTH(DIGITS), .AW(AW)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (walk && r_bit),
        .i_waddr (r_j),
        .i_wdata (res_new),
        .i_raddr (raddr),
        .o_rdata (res_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= '0;
            r_bit       <= 1'b0;
            r_pl        <= LW'(1);
            r_res_len   <= '0;
            r_res_fill  <= '0;
            r_pow_valid <= 1'b0;
            r_bits      <= '0;
            r_hit       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (clear_go) begin
                        r_pl        <= LW'(1);
                        r_res_len   <= '0;
                        r_res_fill  <= '0;
                        r_pow_valid <= 1'b0;
                        r_bits      <= '0;
                    end else if (feed_go) begin
                        r_bits  <= r_bits + BW'(1);
                        r_bit   <= i_bit_value;
                        r_j     <= '0;
                        r_state <= S_WALK;
                    end else if (read_go) begin
                        r_hit   <= (CW'(i_digit_index) < CW'(r_res_len));
                        r_state <= S_READ;
                    end
                end
                S_WALK: begin
                    r_j <= AW'(j_ext + LW'(1));
                    if (walk_last) begin
                        r_state     <= S_IDLE;
                        r_pow_valid <= 1'b1;
                        // At the top position the doubled digit is the carry out
                        if (r_pl < LW'(DIGITS)) begin
                            r_pl <= r_pl + LW'(pow_new[0]);
                        end
                        if (r_bit) begin
                            if ((r_pl < LW'(DIGITS)) && (res_new != '0)) begin
                                r_res_len <= r_pl + LW'(1);
                            end else begin
                                r_res_len <= r_pl;
                            end
                            if ((last + LW'(1)) > r_res_fill) begin
                                r_res_fill <= last + LW'(1);
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = (r_state == S_READ);
    assign o_digit       = r_hit ? res_q : '0;
    assign o_digit_count = COUNT_W'(r_res_len);

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walk && walk_last) |=> (r_state == S_IDLE))
        else $error("digit walk did not end at the top digit");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk |-> (j_ext <= last))
        else $error("digit walk ran past the power length");

    a_len_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_len <= r_res_fill) && (r_pl <= LW'(DIGITS)))
        else $error("result length beyond written digits");

    a_read_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_go |=> (o_valid && busy))
        else $error("read word did not strobe a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(read_go))
        else $error("result strobe without a read word");

endmodule
